>>> src/channel_volume_remix_macros.svh
// Assertion helpers for the checker file.
`ifndef CHANNEL_VOLUME_REMIX_MACROS_SVH
`define CHANNEL_VOLUME_REMIX_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CVR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition is followed in the next cycle by a consequence.
`define CVR_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

>>> src/cvr_pkg.sv
package cvr_pkg;

  localparam int MAX_CHANNELS_DEF = 12;
  localparam int OUT_CHANNELS_DEF = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int SAMPLE_W   = 16;
  localparam int RESULT_W   = 20;
  localparam int GAIN_W     = 16;
  localparam int NUM_GAINS  = 12;
  localparam int CH_W       = 4;
  localparam int OUT_CH_W   = 3;
  localparam int PROD_W     = 33;
  localparam int ACC_W      = 18;

  localparam int UNITY_SHIFT = 15;
  localparam int TRUNC_BIAS  = (1 << UNITY_SHIFT) - 1;
  localparam int INT16_MAX   = 32767;
  localparam int INT16_MIN   = -32768;

  localparam logic [CFG_DATA_W-1:0] GAIN_RESET = 64'h8000_8000_8000_8000;
  localparam logic [1:0]            FORMAT_RESET = 2'd0;
  localparam logic [1:0]            MODE_RESET = 2'd1;

  localparam logic [CH_W-1:0] SWAP_MIN_CH = 4'd8;
  localparam logic [CH_W-1:0] FULL_CH     = 4'd12;

  localparam logic [CH_W-1:0]     MODE_CHANNELS [4] = '{4'd1, 4'd2, 4'd8, 4'd12};
  localparam logic [OUT_CH_W-1:0] SIDE_BACK_MAP [8] =
    '{3'd0, 3'd1, 3'd2, 3'd3, 3'd6, 3'd7, 3'd4, 3'd5};
  localparam logic [OUT_CH_W-1:0] HEIGHT_TARGET [4] = '{3'd0, 3'd1, 3'd4, 3'd5};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_FORMAT,
    REG_CHANNEL_MODE,
    REG_GAINS_LOW,
    REG_GAINS_MID,
    REG_GAINS_HIGH
  } reg_idx_t;

  typedef struct packed {
    logic                              fixed_mode;
    logic                              std_layout;
    logic [1:0]                        channel_mode;
    logic [NUM_GAINS-1:0][GAIN_W-1:0]  gains;
  } cfg_t;

  typedef struct packed {
    logic                wr;
    logic [CH_W-1:0]     wr_addr;
    logic                mul;
    logic [CH_W-1:0]     rd_ch;
    logic                acc;
    logic                acc_add;
    logic                load_out;
    logic [OUT_CH_W-1:0] out_ch;
    logic                out_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic            hit;
    logic [CH_W-1:0] ch;
  } height_t;

  function automatic height_t height_src(input logic [OUT_CH_W-1:0] pos);
    height_t r;
    r.hit = 1'b0;
    r.ch  = '0;
    for (int i = 0; i < 4; i++) begin
      if (HEIGHT_TARGET[i] == pos) begin
        r.hit = 1'b1;
        r.ch  = SWAP_MIN_CH + CH_W'(i);
      end
    end
    return r;
  endfunction

endpackage

>>> src/cvr_if.sv
interface cvr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [cvr_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface cvr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cvr_pkg::RESULT_W-1:0] sample_out;
  logic [cvr_pkg::OUT_CH_W-1:0]        out_channel;
  logic                                frame_end;

  modport source (output valid, output sample_out, output out_channel, output frame_end,
                  input ready);
  modport sink (input valid, input sample_out, input out_channel, input frame_end,
                output ready);
endinterface

>>> src/cvr_regs.sv
module cvr_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cvr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cvr_pkg::CFG_DATA_W-1:0] cfg_data,
  output cvr_pkg::cfg_t                  cfg
);

  logic [1:0]                        sample_format;
  logic [1:0]                        channel_mode;
  logic [cvr_pkg::CFG_DATA_W-1:0]    gains_low;
  logic [cvr_pkg::CFG_DATA_W-1:0]    gains_mid;
  logic [cvr_pkg::CFG_DATA_W-1:0]    gains_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= cvr_pkg::FORMAT_RESET;
      channel_mode  <= cvr_pkg::MODE_RESET;
      gains_low     <= cvr_pkg::GAIN_RESET;
      gains_mid     <= cvr_pkg::GAIN_RESET;
      gains_high    <= cvr_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      case (cvr_pkg::reg_idx_t'(cfg_index))
        cvr_pkg::REG_SAMPLE_FORMAT: sample_format <= cfg_data[1:0];
        cvr_pkg::REG_CHANNEL_MODE:  channel_mode  <= cfg_data[1:0];
        cvr_pkg::REG_GAINS_LOW:     gains_low     <= cfg_data;
        cvr_pkg::REG_GAINS_MID:     gains_mid     <= cfg_data;
        cvr_pkg::REG_GAINS_HIGH:    gains_high    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.fixed_mode   = sample_format[1];
  assign cfg.std_layout   = sample_format[0];
  assign cfg.channel_mode = channel_mode;
  assign cfg.gains        = {gains_high, gains_mid, gains_low};

endmodule

>>> src/cvr_ctrl.sv
module cvr_ctrl #(
  parameter int MAX_CHANNELS = cvr_pkg::MAX_CHANNELS_DEF,
  parameter int OUT_CHANNELS = cvr_pkg::OUT_CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  cvr_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  cvr_pkg::sts_t sts,
  output cvr_pkg::cmd_t cmd
);

  localparam int PW = $clog2(MAX_CHANNELS);
  localparam logic [cvr_pkg::CH_W-1:0] MAXC = cvr_pkg::CH_W'(MAX_CHANNELS);
  localparam logic [cvr_pkg::CH_W-1:0] OUTC = cvr_pkg::CH_W'(OUT_CHANNELS);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_ACC, S_OUT} state_t;

  state_t                          state;
  logic [PW-1:0]                   pos;
  logic [cvr_pkg::OUT_CH_W-1:0]    p;
  logic                            hgt;

  logic                            accept;
  logic [cvr_pkg::CH_W-1:0]        mode_n;
  logic [cvr_pkg::CH_W-1:0]        nch;
  logic [cvr_pkg::CH_W-1:0]        nout;
  logic                            reorder;
  logic                            height_mix;
  logic [cvr_pkg::CH_W-1:0]        main_ch;
  cvr_pkg::height_t                ht;
  logic                            need_h;
  logic                            last;
  logic                            close;

  always_comb begin
    mode_n     = cvr_pkg::MODE_CHANNELS[cfg.channel_mode];
    nch        = (mode_n > MAXC) ? MAXC : mode_n;
    nout       = (nch > OUTC) ? OUTC : nch;
    reorder    = (nch >= cvr_pkg::SWAP_MIN_CH) && !cfg.std_layout;
    height_mix = cfg.fixed_mode && (nch == cvr_pkg::FULL_CH);
    main_ch    = reorder ? {1'b0, cvr_pkg::SIDE_BACK_MAP[p]} : {1'b0, p};
    ht         = cvr_pkg::height_src(p);
    need_h     = height_mix && ht.hit;
    last       = ({1'b0, p} + 4'd1) == nout;
    close      = (cvr_pkg::CH_W'(pos) + 4'd1) >= nch;
    in_ready   = (state == S_IDLE);
    accept     = in_valid && in_ready;
  end

  always_comb begin
    cmd          = '0;
    cmd.wr       = accept;
    cmd.wr_addr  = cvr_pkg::CH_W'(pos);
    cmd.rd_ch    = hgt ? ht.ch : main_ch;
    cmd.acc_add  = hgt;
    cmd.out_ch   = p;
    cmd.out_last = last;
    case (state)
      S_MUL:   cmd.mul      = 1'b1;
      S_ACC:   cmd.acc      = 1'b1;
      S_OUT:   cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pos   <= '0;
      p     <= '0;
      hgt   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (close) begin
              pos   <= '0;
              p     <= '0;
              hgt   <= 1'b0;
              state <= S_MUL;
            end else begin
              pos <= pos + PW'(1);
            end
          end
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          if (!hgt && need_h) begin
            hgt   <= 1'b1;
            state <= S_MUL;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (sts.out_free) begin
            if (last) begin
              state <= S_IDLE;
            end else begin
              p     <= p + 3'd1;
              hgt   <= 1'b0;
              state <= S_MUL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/cvr_dp.sv
module cvr_dp #(
  parameter int MAX_CHANNELS = cvr_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cvr_pkg::cfg_t                       cfg,
  input  logic signed [cvr_pkg::SAMPLE_W-1:0] sample_in,
  input  cvr_pkg::cmd_t                       cmd,
  output cvr_pkg::sts_t                       sts,
  cvr_out_if.source                           dout
);

  localparam int PW = $clog2(MAX_CHANNELS);

  logic signed [cvr_pkg::SAMPLE_W-1:0] frame_store [MAX_CHANNELS];
  logic signed [cvr_pkg::PROD_W-1:0]   prod;
  logic signed [cvr_pkg::PROD_W-1:0]   biased;
  logic signed [cvr_pkg::ACC_W-1:0]    prod_q;
  logic signed [cvr_pkg::ACC_W-1:0]    acc;
  logic signed [cvr_pkg::RESULT_W-1:0] sat_val;
  logic                                out_valid;
  logic signed [cvr_pkg::RESULT_W-1:0] sample_out;
  logic [cvr_pkg::OUT_CH_W-1:0]        out_channel;
  logic                                frame_end;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      frame_store[cmd.wr_addr[PW-1:0]] <= sample_in;
    end
    if (cmd.mul) begin
      prod <= frame_store[cmd.rd_ch[PW-1:0]] * $signed({1'b0, cfg.gains[cmd.rd_ch]});
    end
    if (cmd.acc) begin
      acc <= (cmd.acc_add ? acc : '0) + prod_q;
    end
  end

  always_comb begin
    biased = prod + (prod[cvr_pkg::PROD_W-1] ? cvr_pkg::PROD_W'(cvr_pkg::TRUNC_BIAS)
                                             : '0);
    prod_q = biased[cvr_pkg::PROD_W-1:cvr_pkg::UNITY_SHIFT];
    if (cfg.fixed_mode) begin
      sat_val = cvr_pkg::RESULT_W'(acc);
    end else if (acc > cvr_pkg::ACC_W'(cvr_pkg::INT16_MAX)) begin
      sat_val = cvr_pkg::RESULT_W'(cvr_pkg::INT16_MAX);
    end else if (acc < cvr_pkg::ACC_W'(cvr_pkg::INT16_MIN)) begin
      sat_val = cvr_pkg::RESULT_W'(cvr_pkg::INT16_MIN);
    end else begin
      sat_val = cvr_pkg::RESULT_W'(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      sample_out  <= sat_val;
      out_channel <= cmd.out_ch;
      frame_end   <= cmd.out_last;
    end
  end

  assign sts.out_free     = !out_valid || dout.ready;
  assign dout.valid       = out_valid;
  assign dout.sample_out  = sample_out;
  assign dout.out_channel = out_channel;
  assign dout.frame_end   = frame_end;

endmodule

>>> src/channel_volume_remix.sv
// Requests are stored in the frame store. After the one that closes a frame is accepted,
// each of up to OUT_CHANNELS output positions goes through the shared multiply-accumulate
// (twice when a height channel is mixed in) and is registered at the output, waiting while
// a stalled result is held; no new request is taken until the frame's last result is loaded.
// Reset (synchronous, active high) restores the registers to their reset values and
// clears the channel position and the pending request; the frame store is not cleared.
module channel_volume_remix #(
  parameter int MAX_CHANNELS = cvr_pkg::MAX_CHANNELS_DEF,
  parameter int OUT_CHANNELS = cvr_pkg::OUT_CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cvr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cvr_pkg::CFG_DATA_W-1:0] cfg_data,
  cvr_in_if.sink                         din,
  cvr_out_if.source                      dout
);

  cvr_pkg::cfg_t cfg;
  cvr_pkg::cmd_t cmd;
  cvr_pkg::sts_t sts;

  cvr_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cvr_ctrl #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .OUT_CHANNELS (OUT_CHANNELS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cvr_dp #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sample_in (din.sample_in),
    .cmd       (cmd),
    .sts       (sts),
    .dout      (dout)
  );

endmodule

>>> src/cvr_checker.sv
`include "channel_volume_remix_macros.svh"

module cvr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_we,
  input logic [cvr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [cvr_pkg::CFG_DATA_W-1:0] cfg_data,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [cvr_pkg::RESULT_W-1:0]   sample_out,
  input logic [cvr_pkg::OUT_CH_W-1:0]   out_channel,
  input logic                           frame_end
);

  logic                         fmt_fixed;
  logic [cvr_pkg::OUT_CH_W-1:0] exp_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt_fixed <= cvr_pkg::FORMAT_RESET[1];
      exp_ch    <= '0;
    end else begin
      if (cfg_we && cfg_index == cvr_pkg::REG_SAMPLE_FORMAT) begin
        fmt_fixed <= cfg_data[1];
      end
      if (out_valid && out_ready) begin
        exp_ch <= frame_end ? '0 : out_channel + 3'd1;
      end
    end
  end

  `CVR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `CVR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(sample_out) && $stable(out_channel) && $stable(frame_end), "stalled result changed")
  `CVR_ASSERT(a_chan_order, out_valid |-> out_channel == exp_ch, "output channel out of order")
  `CVR_ASSERT(a_int_range, out_valid && !fmt_fixed |-> ($countones(sample_out[19:15]) == 0 || $countones(sample_out[19:15]) == 5), "integer result beyond 16 bits")

endmodule

bind channel_volume_remix cvr_checker u_cvr_checker (
  .clk         (clk),
  .rst         (rst),
  .cfg_we      (cfg_we),
  .cfg_index   (cfg_index),
  .cfg_data    (cfg_data),
  .out_valid   (dout.valid),
  .out_ready   (dout.ready),
  .sample_out  (dout.sample_out),
  .out_channel (dout.out_channel),
  .frame_end   (dout.frame_end)
);
